// ----- sv/accessory_register_file_slave_assert.svh -----
`ifndef ACCESSORY_REGISTER_FILE_SLAVE_ASSERT_SVH
`define ACCESSORY_REGISTER_FILE_SLAVE_ASSERT_SVH

// same-cycle implication under reset
`define ARFS_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication under reset
`define ARFS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- sv/arfs_pkg.sv -----
package arfs_pkg;

    localparam int READ_BURST_DEFAULT = 32;

    localparam logic [1:0] MODE_ADDR  = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_STORE = 2'd3;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_ENABLED = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALTERNATE_ID = 1'd1;

    localparam logic [7:0] POLL_LIMIT  = 8'h09;
    localparam logic [7:0] FORMAT_ADDR = 8'hFE;
    localparam logic [7:0] ID_ADDR     = 8'hFA;
    localparam logic [7:0] LAST_ADDR   = 8'hFF;
    localparam logic [7:0] RESET_FC    = 8'hA4;
    localparam logic [7:0] RESET_FD    = 8'h20;

    localparam logic [7:0] FMT_PACK  = 8'h01;
    localparam logic [7:0] FMT_SHIFT = 8'h02;

    localparam int STATUS_BYTES = 9;
    localparam int POLL_CNT_W   = $clog2(STATUS_BYTES);

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_value;
        logic [7:0] mask_value;
        logic [2:0] slot;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       last;
        logic       status_poll;
    } out_item_t;

    typedef struct packed {
        logic addr_load;
        logic data_write;
        logic store_load;
        logic fmt_read;
        logic fmt_capture;
        logic poll_write;
        logic burst_first;
        logic burst_next;
    } ctl_cmd_t;

    typedef struct packed {
        logic port_enabled;
        logic is_poll;
        logic poll_done;
        logic burst_last;
    } dp_status_t;

    typedef logic [7:0][7:0] ctl_bytes_t;
    typedef logic [STATUS_BYTES-1:0][7:0] status_bytes_t;

    function automatic logic [7:0] reg_reset_value(input logic [7:0] a, input logic alt);
        logic [7:0] v;
        case (a) inside
            [8'h00:8'h14]: v = 8'h00;
            [8'h15:8'h1E]: v = 8'hFF;
            [8'h1F:8'h3F]: v = 8'h00;
            [8'h40:8'hEF]: v = 8'hFF;
            [8'hF0:8'hF9]: v = 8'h00;
            ID_ADDR:       v = alt ? 8'h00 : 8'h01;
            8'hFB:         v = 8'h00;
            8'hFC:         v = RESET_FC;
            8'hFD:         v = RESET_FD;
            default:       v = 8'h01;
        endcase
        return v;
    endfunction

    function automatic status_bytes_t rebuild_status(input ctl_bytes_t data,
                                                     input ctl_bytes_t mask,
                                                     input logic [7:0] fmt);
        status_bytes_t r;
        status_bytes_t t;
        for (int i = 0; i < 6; i++) begin
            r[i] = (mask[i] != 8'h00) ? mask[i] : data[i];
        end
        r[6] = data[6] | mask[6];
        r[7] = data[7] | mask[7];
        r[8] = 8'h00;
        t = r;
        case (fmt)
            FMT_PACK:
            begin
                t[0] = {r[1][7:6], r[0][7:2]};
                t[1] = {r[1][5:4], r[2][7:2]};
                t[2] = {r[1][3], r[4][7:6], r[3][7:3]};
                t[3] = {r[4][5:3], r[5][7:3]};
                t[4] = r[6];
                t[5] = r[7];
                t[6] = 8'h00;
                t[7] = 8'h00;
            end
            FMT_SHIFT:
            begin
                t[8] = r[7];
                t[7] = r[6];
                t[6] = r[5];
                t[5] = r[4];
                t[4] = 8'h00;
            end
            default:
            begin
                t = r;
            end
        endcase
        return t;
    endfunction

endpackage

// ----- sv/arfs_ctrl.sv -----
module arfs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           item_mode,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  arfs_pkg::dp_status_t status,
    output arfs_pkg::ctl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMT_RD,
        S_FMT_CAP,
        S_WRITE,
        S_ISSUE,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_OUT);
    assign take         = item_valid && item_ready && status.port_enabled;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (item_mode)
                        arfs_pkg::MODE_ADDR:  cmd.addr_load  = 1'b1;
                        arfs_pkg::MODE_DATA:  cmd.data_write = 1'b1;
                        arfs_pkg::MODE_STORE: cmd.store_load = 1'b1;
                        default:              state_next = status.is_poll ? S_FMT_RD : S_ISSUE;
                    endcase
                end
            end
            S_FMT_RD:
            begin
                cmd.fmt_read = 1'b1;
                state_next   = S_FMT_CAP;
            end
            S_FMT_CAP:
            begin
                cmd.fmt_capture = 1'b1;
                state_next      = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.poll_write = 1'b1;
                if (status.poll_done)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.burst_first = 1'b1;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (result_ready)
                begin
                    if (status.burst_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.burst_next = 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/arfs_datapath.sv -----
module arfs_datapath #(
    parameter int READ_BURST = arfs_pkg::READ_BURST_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  arfs_pkg::in_item_t                   item,
    input  logic                                 cfg_write,
    input  logic [arfs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [arfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  arfs_pkg::ctl_cmd_t                   cmd,
    output arfs_pkg::dp_status_t                 status,
    output arfs_pkg::out_item_t                  result
);

    localparam int CNT_W = $clog2(READ_BURST + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(READ_BURST - 1);
    localparam logic [arfs_pkg::POLL_CNT_W-1:0] POLL_LAST =
        arfs_pkg::POLL_CNT_W'(arfs_pkg::STATUS_BYTES - 1);

    logic [7:0]                    regfile_mem [256];
    logic [255:0]                  valid_reg;
    arfs_pkg::ctl_bytes_t          ctl_data_reg;
    arfs_pkg::ctl_bytes_t          ctl_mask_reg;
    logic [7:0]                    start_reg;
    logic [7:0]                    cursor_reg;
    logic                          stopped_reg;
    logic                          port_en_reg;
    logic                          alt_reg;
    logic [7:0]                    fmt_reg;
    logic [arfs_pkg::POLL_CNT_W-1:0] poll_cnt_reg;
    logic [CNT_W-1:0]              burst_cnt_reg;
    logic [7:0]                    burst_addr_reg;
    logic                          burst_poll_reg;
    logic                          last_reg;
    logic [7:0]                    rd_data_reg;
    logic                          rd_hit_reg;
    logic [7:0]                    rd_dflt_reg;

    arfs_pkg::status_bytes_t       status_bytes;
    logic                          wr_en;
    logic [7:0]                    wr_addr;
    logic [7:0]                    wr_data;
    logic                          rd_en;
    logic [7:0]                    rd_addr;
    logic [7:0]                    rd_value;
    logic [CNT_W-1:0]              issue_cnt;
    logic                          issue_poll;
    logic                          issue_last;
    logic                          write_ok;

    assign status_bytes = arfs_pkg::rebuild_status(ctl_data_reg, ctl_mask_reg, fmt_reg);
    assign write_ok     = cmd.data_write && !stopped_reg;

    always_comb
    begin
        wr_en   = write_ok || cmd.poll_write;
        wr_addr = cursor_reg;
        wr_data = item.byte_value;
        if (cmd.poll_write)
        begin
            wr_addr = 8'(poll_cnt_reg);
            wr_data = status_bytes[poll_cnt_reg];
        end
    end

    always_comb
    begin
        rd_en      = cmd.fmt_read || cmd.burst_first || cmd.burst_next;
        rd_addr    = arfs_pkg::FORMAT_ADDR;
        issue_cnt  = '0;
        issue_poll = status.is_poll;
        if (cmd.burst_first)
        begin
            rd_addr = start_reg;
        end
        else if (cmd.burst_next)
        begin
            rd_addr    = burst_addr_reg + 8'd1;
            issue_cnt  = burst_cnt_reg + CNT_W'(1);
            issue_poll = burst_poll_reg;
        end
        issue_last = (issue_cnt == CNT_LAST) ||
                     (!issue_poll && (rd_addr == arfs_pkg::LAST_ADDR));
    end

    assign rd_value = rd_hit_reg ? rd_data_reg : rd_dflt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            regfile_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= regfile_mem[rd_addr];
            rd_hit_reg  <= valid_reg[rd_addr];
            rd_dflt_reg <= arfs_pkg::reg_reset_value(rd_addr, alt_reg);
        end
        if (cmd.fmt_capture)
        begin
            fmt_reg <= rd_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            ctl_data_reg   <= '0;
            ctl_mask_reg   <= '0;
            start_reg      <= '0;
            cursor_reg     <= '0;
            stopped_reg    <= 1'b0;
            port_en_reg    <= 1'b1;
            alt_reg        <= 1'b0;
            poll_cnt_reg   <= '0;
            burst_cnt_reg  <= '0;
            burst_addr_reg <= '0;
            burst_poll_reg <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    arfs_pkg::CFG_PORT_ENABLED: port_en_reg <= cfg_data[0];
                    default:
                    begin
                        alt_reg                     <= cfg_data[0];
                        valid_reg[arfs_pkg::ID_ADDR] <= 1'b0;
                    end
                endcase
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.addr_load)
            begin
                start_reg   <= item.byte_value;
                cursor_reg  <= item.byte_value;
                stopped_reg <= 1'b0;
            end
            if (write_ok)
            begin
                if (cursor_reg == arfs_pkg::LAST_ADDR)
                begin
                    stopped_reg <= 1'b1;
                end
                else
                begin
                    cursor_reg <= cursor_reg + 8'd1;
                end
            end
            if (cmd.store_load)
            begin
                ctl_data_reg[item.slot] <= item.byte_value;
                ctl_mask_reg[item.slot] <= item.mask_value;
            end
            if (cmd.fmt_capture)
            begin
                poll_cnt_reg <= '0;
            end
            else if (cmd.poll_write)
            begin
                poll_cnt_reg <= poll_cnt_reg + arfs_pkg::POLL_CNT_W'(1);
            end
            if (cmd.burst_first || cmd.burst_next)
            begin
                burst_cnt_reg  <= issue_cnt;
                burst_addr_reg <= rd_addr;
                burst_poll_reg <= issue_poll;
                last_reg       <= issue_last;
            end
        end
    end

    assign status.port_enabled = port_en_reg;
    assign status.is_poll      = (start_reg < arfs_pkg::POLL_LIMIT);
    assign status.poll_done    = (poll_cnt_reg == POLL_LAST);
    assign status.burst_last   = last_reg;

    assign result.read_data   = rd_value;
    assign result.last        = last_reg;
    assign result.status_poll = burst_poll_reg;

endmodule

// ----- sv/accessory_register_file_slave.sv -----
// Register-file slave of an accessory bus, one item at a time. Address, data-write and
// controller-store items do not leave S_IDLE. A read item passes S_ISSUE, which issues
// the registered read, before its first byte shows, then one byte per cycle while
// result_ready stays high, up to READ_BURST bytes (fewer near the top of the file). A
// status poll (start address below 0x09) first fetches the format byte at 0xFE in
// S_FMT_RD and S_FMT_CAP and writes the 9 rebuilt status bytes in S_WRITE, all through
// the register file's single write and single registered read port. Reset contents
// come from a per-entry valid bit and the reset table; no clearing pass after reset.
`include "accessory_register_file_slave_assert.svh"

module accessory_register_file_slave #(
    parameter int READ_BURST = arfs_pkg::READ_BURST_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  arfs_pkg::in_item_t               item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output arfs_pkg::out_item_t              result,
    input  logic                             cfg_write,
    input  logic [arfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [arfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    arfs_pkg::ctl_cmd_t   cmd;
    arfs_pkg::dp_status_t status;

    arfs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_mode    (item.mode),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    arfs_datapath #(
        .READ_BURST (READ_BURST)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    `ARFS_ASSERT_NOW(a_no_overlap, clk, rst_n, result_valid, !item_ready,
        "item taken while a burst is pending")

    `ARFS_ASSERT_NEXT(a_burst_continues, clk, rst_n,
        result_valid && result_ready && !result.last, result_valid,
        "burst ended without a last byte")

    `ARFS_ASSERT_NEXT(a_last_frees, clk, rst_n,
        result_valid && result_ready && result.last, item_ready,
        "block not ready after last byte")

    `ARFS_ASSERT_NEXT(a_short_items, clk, rst_n,
        item_valid && item_ready && (item.mode != arfs_pkg::MODE_READ), item_ready,
        "non-read item held the block")

endmodule
